### rtl/core/stq_pkg.sv
// stq_pkg: shared types and constants for the sorted timer queue
// no dependencies; used by sorted_timer_queue by scoped names

package stq_pkg;

	// width of deadlines, reload periods and the current time
	localparam int TIME_W = 32;

	// input transaction kinds
	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_START = 2'd1,
		KIND_STOP  = 2'd2,
		KIND_QUERY = 2'd3
	} kind_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_ADD,
		ST_SCAN,
		ST_INSERT,
		ST_HEAD,
		ST_HEADRD,
		ST_OUT
	} state_t;

endpackage

### rtl/core/sorted_timer_queue.sv
// sorted_timer_queue: timer slots kept in deadline order under a small sequencer
// depends on stq_pkg (kind and state types, time width)

// Each slot keeps its deadline and reload period in two small memories with one
// registered read port, plus an armed flag and a rank in flip-flops (rank 0 is the
// earliest; equal deadlines keep arrival order). One transaction is handled at a
// time and in_ready is low until its last result is taken. Query and an out-of-range
// slot read the head and then give the result; stop first takes the slot out of the
// order. Start takes it out, stores it, and then the single deadline comparator walks
// the deadline memory one slot a cycle to find the insert position and opens a gap
// there. A tick reads the head and gives one result when nothing is due, or else,
// for each firing, removes the head (one-shot) or also reloads its deadline and
// reinserts it by that one scan (periodic); at most MAX_FIRE slots fire per tick.
// Results wait in an output register; no reset-time clearing pass is needed.

module sorted_timer_queue #(
	parameter int NUM_TIMERS = 16,
	parameter int MAX_FIRE   = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 kind,
	input  logic [3:0]                 timer_id,
	input  logic [stq_pkg::TIME_W-1:0] deadline,
	input  logic [stq_pkg::TIME_W-1:0] reload_period,
	input  logic [stq_pkg::TIME_W-1:0] now,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       fired,
	output logic [3:0]                 fired_id,
	output logic                       running,
	output logic                       any_pending,
	output logic [stq_pkg::TIME_W-1:0] next_deadline,
	output logic                       last
);

	localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int SCAN_W = $clog2(NUM_TIMERS + 1);
	localparam int FIRE_W = $clog2(MAX_FIRE + 1);
	localparam int IDX_W  = SLOT_W + 4;
	localparam int TW     = stq_pkg::TIME_W;

	stq_pkg::state_t state_q, state_d;
	stq_pkg::kind_t  kind_q;

	logic              id_ok_q;
	logic [SLOT_W-1:0] s_q;
	logic [TW-1:0]     key_q;
	logic [TW-1:0]     per_q;
	logic [TW-1:0]     now_q;
	logic [SCAN_W-1:0] scan_q;
	logic [SLOT_W-1:0] cnt_q;
	logic [SLOT_W-1:0] head_q;
	logic              has_q;
	logic [FIRE_W-1:0] n_q;
	logic              pend_q;

	logic [NUM_TIMERS-1:0] armed_q;
	logic [SLOT_W-1:0]     rank_q [NUM_TIMERS];

	logic [TW-1:0] dl_mem  [NUM_TIMERS];
	logic [TW-1:0] per_mem [NUM_TIMERS];
	logic [TW-1:0] dl_rd_q;
	logic [TW-1:0] per_rd_q;

	logic          out_valid_q;
	logic          out_fired_q;
	logic [3:0]    out_id_q;
	logic          out_running_q;
	logic          out_any_q;
	logic [TW-1:0] out_nd_q;
	logic          out_last_q;

	logic [IDX_W-1:0]      id_ext;
	logic [IDX_W-1:0]      s_ext;
	logic                  id_ok_in;
	logic [NUM_TIMERS-1:0] head_match_c;
	logic [SLOT_W-1:0]     head_c;
	logic                  has_c;
	logic                  can_fire;
	logic                  fire_now;
	logic                  fire_after;
	logic                  rd_en;
	logic [SLOT_W-1:0]     rd_addr;
	logic                  dl_we;
	logic                  per_we;
	logic [TW-1:0]         dl_wdata;
	logic [TW-1:0]         reload_sum;
	logic [SLOT_W-1:0]     scan_idx;
	logic                  scan_hit;

	// slot number checks
	assign id_ext   = IDX_W'(timer_id);
	assign id_ok_in = id_ext < IDX_W'(NUM_TIMERS);
	assign s_ext    = IDX_W'(s_q);

	// head of the order: the one armed slot at rank 0
	always_comb begin
		head_c = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			head_match_c[i] = armed_q[i] && (rank_q[i] == '0);
			if (head_match_c[i])
				head_c = head_c | SLOT_W'(i);
		end
		has_c = |head_match_c;
	end

	// shared adder and comparator
	assign reload_sum = dl_rd_q + per_rd_q;
	assign dl_wdata   = (state_q == stq_pkg::ST_ADD) ? reload_sum : key_q;
	assign scan_idx   = SLOT_W'(scan_q - 1'b1);
	assign scan_hit   = (scan_q != '0) && armed_q[scan_idx] && (dl_rd_q <= key_q);
	assign can_fire   = has_q && !(now_q < dl_rd_q) && (n_q < FIRE_W'(MAX_FIRE));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory controls
	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		rd_addr    = head_c;
		dl_we      = 1'b0;
		per_we     = 1'b0;
		fire_now   = 1'b0;
		fire_after = 1'b0;
		case (state_q)
			stq_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (stq_pkg::kind_t'(kind) == stq_pkg::KIND_TICK)
						state_d = stq_pkg::ST_HEAD;
					else if (id_ok_in && (stq_pkg::kind_t'(kind) == stq_pkg::KIND_START ||
						stq_pkg::kind_t'(kind) == stq_pkg::KIND_STOP))
						state_d = stq_pkg::ST_REMOVE;
					else
						state_d = stq_pkg::ST_HEAD;
				end
			end
			stq_pkg::ST_REMOVE: begin
				if (kind_q == stq_pkg::KIND_START) begin
					dl_we   = 1'b1;
					per_we  = 1'b1;
					state_d = stq_pkg::ST_SCAN;
				end else if (kind_q == stq_pkg::KIND_TICK && per_rd_q != '0) begin
					state_d = stq_pkg::ST_ADD;
				end else begin
					state_d = stq_pkg::ST_HEAD;
				end
			end
			stq_pkg::ST_ADD: begin
				dl_we   = 1'b1;
				state_d = stq_pkg::ST_SCAN;
			end
			stq_pkg::ST_SCAN: begin
				rd_addr = scan_q[SLOT_W-1:0];
				rd_en   = scan_q < SCAN_W'(NUM_TIMERS);
				if (scan_q == SCAN_W'(NUM_TIMERS))
					state_d = stq_pkg::ST_INSERT;
			end
			stq_pkg::ST_INSERT: begin
				state_d = stq_pkg::ST_HEAD;
			end
			stq_pkg::ST_HEAD: begin
				rd_en   = 1'b1;
				state_d = stq_pkg::ST_HEADRD;
			end
			stq_pkg::ST_HEADRD: begin
				if (kind_q == stq_pkg::KIND_TICK && !pend_q && can_fire) begin
					fire_now = 1'b1;
					state_d  = stq_pkg::ST_REMOVE;
				end else begin
					state_d = stq_pkg::ST_OUT;
				end
			end
			stq_pkg::ST_OUT: begin
				if (out_ready) begin
					if (kind_q == stq_pkg::KIND_TICK && !out_last_q) begin
						fire_after = 1'b1;
						state_d    = stq_pkg::ST_REMOVE;
					end else begin
						state_d = stq_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = stq_pkg::ST_IDLE;
			end
		endcase
	end

	// slot memories, registered read
	always_ff @(posedge clk) begin
		if (dl_we)
			dl_mem[s_q] <= dl_wdata;
		if (per_we)
			per_mem[s_q] <= per_q;
		if (rd_en) begin
			dl_rd_q  <= dl_mem[rd_addr];
			per_rd_q <= per_mem[rd_addr];
		end
	end

	// order bookkeeping, sequencer datapath and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q        <= stq_pkg::KIND_TICK;
			id_ok_q       <= 1'b0;
			s_q           <= '0;
			key_q         <= '0;
			per_q         <= '0;
			now_q         <= '0;
			scan_q        <= '0;
			cnt_q         <= '0;
			head_q        <= '0;
			has_q         <= 1'b0;
			n_q           <= '0;
			pend_q        <= 1'b0;
			armed_q       <= '0;
			for (int i = 0; i < NUM_TIMERS; i++)
				rank_q[i] <= '0;
			out_valid_q   <= 1'b0;
			out_fired_q   <= 1'b0;
			out_id_q      <= '0;
			out_running_q <= 1'b0;
			out_any_q     <= 1'b0;
			out_nd_q      <= '0;
			out_last_q    <= 1'b0;
		end else begin
			case (state_q)
				// capture the transaction
				stq_pkg::ST_IDLE: begin
					if (in_valid) begin
						kind_q  <= stq_pkg::kind_t'(kind);
						id_ok_q <= id_ok_in;
						s_q     <= id_ext[SLOT_W-1:0];
						key_q   <= deadline;
						per_q   <= reload_period;
						now_q   <= now;
						n_q     <= '0;
						pend_q  <= 1'b0;
					end
				end
				// take the slot out of the order
				stq_pkg::ST_REMOVE: begin
					if (armed_q[s_q]) begin
						for (int i = 0; i < NUM_TIMERS; i++)
							if (armed_q[i] && rank_q[i] > rank_q[s_q])
								rank_q[i] <= rank_q[i] - 1'b1;
						armed_q[s_q] <= 1'b0;
						rank_q[s_q]  <= '0;
					end
					scan_q <= '0;
					cnt_q  <= '0;
				end
				// periodic reload, wraps modulo the time width
				stq_pkg::ST_ADD: begin
					key_q <= reload_sum;
				end
				// count armed slots due at or before the key
				stq_pkg::ST_SCAN: begin
					if (scan_q != SCAN_W'(NUM_TIMERS))
						scan_q <= scan_q + 1'b1;
					if (scan_hit)
						cnt_q <= cnt_q + 1'b1;
				end
				// open a gap at the insert position
				stq_pkg::ST_INSERT: begin
					for (int i = 0; i < NUM_TIMERS; i++)
						if (armed_q[i] && rank_q[i] >= cnt_q)
							rank_q[i] <= rank_q[i] + 1'b1;
					rank_q[s_q]  <= cnt_q;
					armed_q[s_q] <= 1'b1;
				end
				stq_pkg::ST_HEAD: begin
					head_q <= head_c;
					has_q  <= has_c;
				end
				// build the result or fire the head
				stq_pkg::ST_HEADRD: begin
					if (fire_now) begin
						s_q    <= head_q;
						n_q    <= n_q + 1'b1;
						pend_q <= 1'b1;
					end else begin
						out_valid_q <= 1'b1;
						out_any_q   <= has_q;
						out_nd_q    <= has_q ? dl_rd_q : '0;
						if (kind_q == stq_pkg::KIND_TICK) begin
							out_fired_q   <= pend_q;
							out_id_q      <= pend_q ? s_ext[3:0] : 4'd0;
							out_running_q <= 1'b0;
							out_last_q    <= pend_q ? !can_fire : 1'b1;
						end else begin
							out_fired_q   <= 1'b0;
							out_id_q      <= 4'd0;
							out_running_q <= id_ok_q && armed_q[s_q];
							out_last_q    <= 1'b1;
						end
					end
				end
				stq_pkg::ST_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (fire_after) begin
							s_q    <= head_q;
							n_q    <= n_q + 1'b1;
							pend_q <= 1'b1;
						end
					end
				end
				default: begin
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_ready      = (state_q == stq_pkg::ST_IDLE);
	assign out_valid     = out_valid_q;
	assign fired         = out_fired_q;
	assign fired_id      = out_id_q;
	assign running       = out_running_q;
	assign any_pending   = out_any_q;
	assign next_deadline = out_nd_q;
	assign last          = out_last_q;

	// at most one armed slot holds rank 0
	a_single_head: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(head_match_c))
		else $error("more than one armed slot at rank 0");

	// a waiting result blocks new transactions
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while a result waits");

	// every result that is not the last one reports a firing
	a_nonlast_fired: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> fired)
		else $error("non-final result without a firing");

	// firing count per tick stays within its limit
	a_fire_limit: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= FIRE_W'(MAX_FIRE))
		else $error("too many firings in one tick");

endmodule
